@@ rtl/rar_pkg.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic reduce - shared package
// Operation codes, sequencer states and field widths used by the core and
// its iterative arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package rar_pkg;

    localparam int OPND_W = 16;            // input operand width
    localparam int PROD_W = 2 * OPND_W;    // multiplier product width
    localparam int SUM_W  = PROD_W + 1;    // cross-product sum width
    localparam int MAG_W  = 32;            // magnitude width for gcd / divide
    localparam int NUM_W  = 32;            // result numerator width
    localparam int DEN_W  = 30;            // result denominator width
    localparam int KIND_W = 3;
    localparam int SHIFT_W = $clog2(MAG_W);        // trailing-zero count
    localparam int DIV_CNT_W = $clog2(MAG_W) + 1;  // divider step count

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD = 3'd0,
        KIND_SUB = 3'd1,
        KIND_MUL = 3'd2,
        KIND_DIV = 3'd3,
        KIND_RED = 3'd4
    } t_kind;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL  = 8'b0000_0010,
        ST_SUM  = 8'b0000_0100,
        ST_CHK  = 8'b0000_1000,
        ST_GCD  = 8'b0001_0000,
        ST_DIVN = 8'b0010_0000,
        ST_DIVD = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } t_state;

    localparam logic signed [OPND_W-1:0] OPND_ONE  = OPND_W'(1);
    localparam logic signed [OPND_W-1:0] OPND_ZERO = '0;
    localparam logic [NUM_W-1:0] NUM_POS_SAT = {1'b0, {(NUM_W-1){1'b1}}};
    localparam logic [NUM_W-1:0] NUM_NEG_SAT = {1'b1, {(NUM_W-1){1'b0}}};
    localparam logic [DEN_W-1:0] DEN_SAT     = {DEN_W{1'b1}};

endpackage

`default_nettype wire

@@ rtl/rational_arith_reduce_core.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic reduce - top level
// Adds, subtracts, multiplies or divides two signed 16-bit fractions, or
// reduces the first one, and returns the result in lowest terms.
//
// Input channel i_in_valid / o_in_ready carries kind and the four operands;
// output channel o_out_valid / i_out_ready carries the reduced numerator,
// the denominator and the zero-denominator flag. One result per transaction.
// The three cross products go through one shared registered multiplier.
// A zero denominator or zero numerator is answered from the check state
// without the gcd. Otherwise an iterative binary gcd (one shift or
// subtract per cycle) is followed by two restoring divisions in one
// shared divider; the gcd loop is the only part whose run time varies
// with the operands.
// One item is in work at a time: o_in_ready is high only when the sequencer
// is idle. The result sits in an output register, so a new transaction is
// taken while the previous result waits; if the receiver still stalls when
// the next result is done, the sequencer holds it until the register frees.
// Reset clears the sequencer and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arith_reduce_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic        [rar_pkg::KIND_W-1:0]   i_kind,
    input  wire logic signed [rar_pkg::OPND_W-1:0]   i_a_num,
    input  wire logic signed [rar_pkg::OPND_W-1:0]   i_a_den,
    input  wire logic signed [rar_pkg::OPND_W-1:0]   i_b_num,
    input  wire logic signed [rar_pkg::OPND_W-1:0]   i_b_den,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed      [rar_pkg::NUM_W-1:0]    o_result_num,
    output logic             [rar_pkg::DEN_W-1:0]    o_result_den,
    output logic                                     o_zero_den
);

    rar_pkg::t_state r_state, n_state;
    logic [1:0]      r_step, n_step;

    rar_pkg::t_kind                   r_kind, n_kind;
    logic signed [rar_pkg::OPND_W-1:0] r_an, n_an, r_ad, n_ad;
    logic signed [rar_pkg::OPND_W-1:0] r_bn, n_bn, r_bd, n_bd;
    logic signed [rar_pkg::PROD_W-1:0] r_m1, n_m1, r_m2, n_m2, r_m3, n_m3;
    logic signed [rar_pkg::SUM_W-1:0]  r_num, n_num;
    logic signed [rar_pkg::PROD_W-1:0] r_den, n_den;
    logic                              r_neg, n_neg;
    logic [rar_pkg::MAG_W-1:0]         r_un, n_un, r_ud, n_ud, r_qn, n_qn;

    logic [rar_pkg::NUM_W-1:0]         r_res_num, n_res_num;
    logic [rar_pkg::DEN_W-1:0]         r_res_den, n_res_den;
    logic                              r_res_zd, n_res_zd;

    logic                              r_out_valid, n_out_valid;
    logic [rar_pkg::NUM_W-1:0]         r_out_num, n_out_num;
    logic [rar_pkg::DEN_W-1:0]         r_out_den, n_out_den;
    logic                              r_out_zd, n_out_zd;

    logic signed [rar_pkg::OPND_W-1:0] w_ma, w_mb;
    logic signed [rar_pkg::PROD_W-1:0] w_prod;
    logic                              w_gcd_start, w_gcd_done;
    logic [rar_pkg::MAG_W-1:0]         w_gcd_g;
    logic                              w_div_start, w_div_done;
    logic [rar_pkg::MAG_W-1:0]         w_div_dividend, w_div_q;
    logic signed [rar_pkg::SUM_W-1:0]  w_num_abs;
    logic signed [rar_pkg::PROD_W-1:0] w_den_abs;
    logic [rar_pkg::NUM_W-1:0]         w_num_sat;
    logic [rar_pkg::NUM_W-1:0]         w_qn_signed;
    logic                              w_in_acc;
    logic                              w_out_free;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // operand select for the shared multiplier: step 0 first product,
    // step 1 second product (zero unless add or subtract), step 2 denominator
    always_comb begin
        w_ma = r_ad;
        w_mb = r_bd;
        unique case (r_step)
            2'd0: begin
                w_ma = r_an;
                unique case (r_kind)
                    rar_pkg::KIND_ADD, rar_pkg::KIND_SUB,
                    rar_pkg::KIND_DIV: w_mb = r_bd;
                    rar_pkg::KIND_MUL: w_mb = r_bn;
                    default:           w_mb = rar_pkg::OPND_ONE;
                endcase
            end
            2'd1: begin
                if (r_kind == rar_pkg::KIND_ADD || r_kind == rar_pkg::KIND_SUB) begin
                    w_ma = r_bn;
                    w_mb = r_ad;
                end else begin
                    w_ma = rar_pkg::OPND_ZERO;
                    w_mb = rar_pkg::OPND_ZERO;
                end
            end
            default: begin
                w_ma = r_ad;
                unique case (r_kind)
                    rar_pkg::KIND_ADD, rar_pkg::KIND_SUB,
                    rar_pkg::KIND_MUL: w_mb = r_bd;
                    rar_pkg::KIND_DIV: w_mb = r_bn;
                    default:           w_mb = rar_pkg::OPND_ONE;
                endcase
            end
        endcase
    end

    rar_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    // the gcd loads in the check state, so feed it the magnitudes directly
    rar_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_a     (w_num_abs[rar_pkg::MAG_W-1:0]),
        .i_b     (w_den_abs[rar_pkg::MAG_W-1:0]),
        .o_done  (w_gcd_done),
        .o_g     (w_gcd_g)
    );

    assign w_div_dividend = (r_state == rar_pkg::ST_GCD) ? r_un : r_ud;

    rar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_gcd_g),
        .o_done     (w_div_done),
        .o_q        (w_div_q)
    );

    assign w_num_abs = r_num[rar_pkg::SUM_W-1] ? -r_num : r_num;
    assign w_den_abs = r_den[rar_pkg::PROD_W-1] ? -r_den : r_den;

    // clamp the unreduced numerator into the result field
    always_comb begin
        priority if (!r_num[rar_pkg::SUM_W-1] && r_num[rar_pkg::SUM_W-2]) begin
            w_num_sat = rar_pkg::NUM_POS_SAT;
        end else if (r_num[rar_pkg::SUM_W-1] && !r_num[rar_pkg::SUM_W-2]) begin
            w_num_sat = rar_pkg::NUM_NEG_SAT;
        end else begin
            w_num_sat = r_num[rar_pkg::NUM_W-1:0];
        end
    end

    assign w_qn_signed = r_neg ? -r_qn
                       : (r_qn[rar_pkg::NUM_W-1] ? rar_pkg::NUM_POS_SAT : r_qn);

    assign w_gcd_start = (r_state == rar_pkg::ST_CHK) && (r_den != '0) && (r_num != '0);
    assign w_div_start = ((r_state == rar_pkg::ST_GCD) || (r_state == rar_pkg::ST_DIVN))
                         && ((r_state == rar_pkg::ST_GCD) ? w_gcd_done : w_div_done);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_kind      = r_kind;
        n_an        = r_an;
        n_ad        = r_ad;
        n_bn        = r_bn;
        n_bd        = r_bd;
        n_m1        = r_m1;
        n_m2        = r_m2;
        n_m3        = r_m3;
        n_num       = r_num;
        n_den       = r_den;
        n_neg       = r_neg;
        n_un        = r_un;
        n_ud        = r_ud;
        n_qn        = r_qn;
        n_res_num   = r_res_num;
        n_res_den   = r_res_den;
        n_res_zd    = r_res_zd;
        n_out_valid = r_out_valid;
        n_out_num   = r_out_num;
        n_out_den   = r_out_den;
        n_out_zd    = r_out_zd;

        // drop the result once the receiver takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            rar_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_kind  = rar_pkg::t_kind'(i_kind);
                    n_an    = i_a_num;
                    n_ad    = i_a_den;
                    n_bn    = i_b_num;
                    n_bd    = i_b_den;
                    n_step  = '0;
                    n_state = rar_pkg::ST_MUL;
                end
            end
            rar_pkg::ST_MUL: begin
                unique case (r_step)
                    2'd1:    n_m1 = w_prod;
                    2'd2:    n_m2 = w_prod;
                    2'd3:    n_m3 = w_prod;
                    default: ;
                endcase
                n_step = r_step + 1'b1;
                if (r_step == 2'd3) begin
                    n_state = rar_pkg::ST_SUM;
                end
            end
            rar_pkg::ST_SUM: begin
                if (r_kind == rar_pkg::KIND_SUB) begin
                    n_num = rar_pkg::SUM_W'(r_m1) - rar_pkg::SUM_W'(r_m2);
                end else begin
                    n_num = rar_pkg::SUM_W'(r_m1) + rar_pkg::SUM_W'(r_m2);
                end
                n_den   = r_m3;
                n_state = rar_pkg::ST_CHK;
            end
            rar_pkg::ST_CHK: begin
                priority if (r_den == '0) begin
                    n_res_num = w_num_sat;
                    n_res_den = '0;
                    n_res_zd  = 1'b1;
                    n_state   = rar_pkg::ST_FIN;
                end else if (r_num == '0) begin
                    n_res_num = '0;
                    n_res_den = rar_pkg::DEN_W'(1);
                    n_res_zd  = 1'b0;
                    n_state   = rar_pkg::ST_FIN;
                end else begin
                    n_neg   = r_num[rar_pkg::SUM_W-1] ^ r_den[rar_pkg::PROD_W-1];
                    n_un    = w_num_abs[rar_pkg::MAG_W-1:0];
                    n_ud    = w_den_abs[rar_pkg::MAG_W-1:0];
                    n_state = rar_pkg::ST_GCD;
                end
            end
            rar_pkg::ST_GCD: begin
                if (w_gcd_done) begin
                    n_state = rar_pkg::ST_DIVN;
                end
            end
            rar_pkg::ST_DIVN: begin
                if (w_div_done) begin
                    n_qn    = w_div_q;
                    n_state = rar_pkg::ST_DIVD;
                end
            end
            rar_pkg::ST_DIVD: begin
                if (w_div_done) begin
                    n_res_num = w_qn_signed;
                    n_res_den = (w_div_q[rar_pkg::MAG_W-1:rar_pkg::DEN_W] != '0)
                              ? rar_pkg::DEN_SAT : w_div_q[rar_pkg::DEN_W-1:0];
                    n_res_zd  = 1'b0;
                    n_state   = rar_pkg::ST_FIN;
                end
            end
            rar_pkg::ST_FIN: begin
                // hold the result until the output register frees
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_num   = r_res_num;
                    n_out_den   = r_res_den;
                    n_out_zd    = r_res_zd;
                    n_state     = rar_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rar_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rar_pkg::ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_kind    <= n_kind;
        r_an      <= n_an;
        r_ad      <= n_ad;
        r_bn      <= n_bn;
        r_bd      <= n_bd;
        r_m1      <= n_m1;
        r_m2      <= n_m2;
        r_m3      <= n_m3;
        r_num     <= n_num;
        r_den     <= n_den;
        r_neg     <= n_neg;
        r_un      <= n_un;
        r_ud      <= n_ud;
        r_qn      <= n_qn;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_res_zd  <= n_res_zd;
        r_out_num <= n_out_num;
        r_out_den <= n_out_den;
        r_out_zd  <= n_out_zd;
    end

    assign o_in_ready   = (r_state == rar_pkg::ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_result_num = r_out_num;
    assign o_result_den = r_out_den;
    assign o_zero_den   = r_out_zd;

endmodule

`default_nettype wire

@@ rtl/rar_mul.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic reduce - registered signed multiplier
// One 16x16 signed product per cycle, result registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rar_mul (
    input  wire logic                               i_clk,
    input  wire logic signed [rar_pkg::OPND_W-1:0]  i_a,
    input  wire logic signed [rar_pkg::OPND_W-1:0]  i_b,
    output logic signed      [rar_pkg::PROD_W-1:0]  o_p
);

    logic signed [rar_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

@@ rtl/rar_gcd.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic reduce - binary gcd unit
// Iterative binary gcd of two nonzero magnitudes, one shift or one
// subtract per cycle. o_done pulses for one cycle with o_g valid.
// ----------------------------------------------------------------------------
`default_nettype none

module rar_gcd (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [rar_pkg::MAG_W-1:0]  i_a,
    input  wire logic [rar_pkg::MAG_W-1:0]  i_b,
    output logic                            o_done,
    output logic      [rar_pkg::MAG_W-1:0]  o_g
);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [rar_pkg::MAG_W-1:0]    r_a, n_a;
    logic [rar_pkg::MAG_W-1:0]    r_b, n_b;
    logic [rar_pkg::SHIFT_W-1:0]  r_k, n_k;
    logic [rar_pkg::MAG_W-1:0]    r_g, n_g;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_a    = r_a;
        n_b    = r_b;
        n_k    = r_k;
        n_g    = r_g;
        if (i_start) begin
            n_busy = 1'b1;
            n_a    = i_a;
            n_b    = i_b;
            n_k    = '0;
        end else if (r_busy) begin
            priority if (r_b == '0) begin
                n_g    = r_a << r_k;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else if (!r_a[0] && !r_b[0]) begin
                n_a = r_a >> 1;
                n_b = r_b >> 1;
                n_k = r_k + 1'b1;
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (r_a > r_b) begin
                // both odd: keep the smaller, difference is even
                n_a = r_b;
                n_b = r_a - r_b;
            end else begin
                n_b = r_b - r_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_k <= n_k;
        r_g <= n_g;
    end

    assign o_done = r_done;
    assign o_g    = r_g;

endmodule

`default_nettype wire

@@ rtl/rar_div.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic reduce - restoring divider
// Unsigned 32-bit restoring division, one quotient bit per cycle.
// o_done pulses for one cycle with o_q valid. Divisor must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module rar_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [rar_pkg::MAG_W-1:0]  i_dividend,
    input  wire logic [rar_pkg::MAG_W-1:0]  i_divisor,
    output logic                            o_done,
    output logic      [rar_pkg::MAG_W-1:0]  o_q
);

    localparam int W = rar_pkg::MAG_W;

    logic                             r_busy, n_busy;
    logic                             r_done, n_done;
    logic [rar_pkg::DIV_CNT_W-1:0]    r_cnt, n_cnt;
    logic [W-1:0]                     r_q, n_q;
    logic [W-1:0]                     r_r, n_r;
    logic [W-1:0]                     r_d, n_d;
    logic [W:0]                       w_sh;
    logic [W:0]                       w_diff;
    logic                             w_fit;

    assign w_sh   = {r_r, r_q[W-1]};
    assign w_fit  = w_sh >= {1'b0, r_d};
    assign w_diff = w_sh - {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_r    = '0;
            n_d    = i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so W bits hold it
            n_r   = w_fit ? w_diff[W-1:0] : w_sh[W-1:0];
            n_q   = {r_q[W-2:0], w_fit};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == rar_pkg::DIV_CNT_W'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

`default_nettype wire

@@ rtl/rar_chk.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic reduce - port checker
// Watches the core's ports and flags handshake and result-form violations.
// ----------------------------------------------------------------------------
`default_nettype none

module rar_chk (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               o_in_ready,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_ready,
    input wire logic signed [rar_pkg::NUM_W-1:0]   o_result_num,
    input wire logic        [rar_pkg::DEN_W-1:0]   o_result_den,
    input wire logic                               o_zero_den
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_result_num) && $stable(o_result_den)
            && $stable(o_zero_den))
        else $error("result changed while stalled");

    // a transaction starts the sequencer, so the input side closes
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while busy");

    // zero-denominator results carry a zero denominator, others a positive one
    a_den_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_zero_den == (o_result_den == '0)))
        else $error("denominator does not match zero_den");

    // a zero fraction is always 0/1
    a_zero_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_zero_den && (o_result_num == '0) |-> (o_result_den == 1))
        else $error("zero numerator not reduced to 0/1");

endmodule

bind rational_arith_reduce_core rar_chk u_rar_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_result_num (o_result_num),
    .o_result_den (o_result_den),
    .o_zero_den   (o_zero_den)
);

`default_nettype wire
